// ----- rtl/radio_frame_deframer_crc8_top_macros.svh -----
// Assertion helpers for the deframer checker
`ifndef RADIO_FRAME_DEFRAMER_CRC8_TOP_MACROS_SVH
`define RADIO_FRAME_DEFRAMER_CRC8_TOP_MACROS_SVH

// same-cycle implication
`define RFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// next-cycle implication
`define RFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

// ----- rtl/rfd_pkg.sv -----
package rfd_pkg;

    localparam int HEADER_LEN = 9;
    localparam int HDR_IDX_W = $clog2(HEADER_LEN);
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam logic [8:0] HDR_COUNT = 9'(HEADER_LEN);
    localparam logic [8:0] COUNT_MAX = 9'd511;
    localparam logic [7:0] CRC_POLY = 8'h07;

    typedef enum logic [0:0] {
        REG_NET_ID        = 1'b0,
        REG_PROTO_VERSION = 1'b1
    } reg_idx_t;

    typedef enum logic [0:0] {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_VERSION = 3'd2,
        ST_NETWORK = 3'd3,
        ST_LENGTH  = 3'd4,
        ST_CRC     = 3'd5
    } status_t;

    typedef struct packed {
        kind_t       result_kind;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [3:0]  frame_flags;
        logic [7:0]  msg_type;
        logic [7:0]  building;
        logic [15:0] room;
        logic [7:0]  unit_number;
        logic [7:0]  transaction;
        logic [7:0]  payload_len;
    } result_t;

    // CRC-8, MSB first, one byte per call
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/radio_frame_deframer_crc8_top.sv -----
// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------
// s_*       | s_tvalid / s_tready  | s_tdata: rx_byte; s_tlast: end_of_frame
// m_*       | m_tvalid / m_tready  | m_tuser: result_kind; m_tdata: see port
// cfg_*     | cfg_we               | cfg_addr: 0 net_id, 1 proto_version
//
// One item per cycle while the result queue is not full; the CRC-8 is updated a byte at a time.
// A result passes through the result queue and then the output register on its way to m_*.
// Reset clears frame state, queue and output stage; header bytes hold no reset.
// s_tready drops only while the result queue is full; items that give no
// result still wait for a free queue slot.
module radio_frame_deframer_crc8_top
    import rfd_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] payload_byte, [10:8] status, [14:11] frame_flags, [22:15] msg_type,
    // [30:23] building, [46:31] room, [54:47] unit_number, [62:55] transaction,
    // [70:63] payload_len, [71] zero
    output logic [71:0] m_tdata,
    output logic [0:0]  m_tuser    // [0] result_kind
);

    logic    push;
    result_t entry;
    logic    q_full;
    logic    q_pop;
    logic    q_valid;
    result_t q_data;
    result_t out_data;

    rfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .q_full   (q_full),
        .push     (push),
        .entry    (entry)
    );

    rfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    rfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tuser = out_data.result_kind;
    assign m_tdata = {1'b0, out_data.payload_len, out_data.transaction, out_data.unit_number,
                      out_data.room, out_data.building, out_data.msg_type,
                      out_data.frame_flags, out_data.status, out_data.payload_byte};

endmodule

// ----- rtl/rfd_front.sv -----
module rfd_front
    import rfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [0:0] cfg_addr,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       in_ready,
    input  logic       q_full,
    output logic       push,
    output result_t    entry
);

    logic [7:0] net_id_reg;
    logic [3:0] proto_reg;
    logic [8:0] count_reg, count_next;
    logic [7:0] crc_reg, crc_next;
    logic       ver_bad_reg, ver_bad_next;
    logic       net_bad_reg, net_bad_next;
    logic [7:0] hdr_reg [HEADER_LEN];
    logic       hdr_we;
    logic       accept;
    logic [8:0] expected_count;

    assign in_ready = !q_full;
    assign accept = in_valid && in_ready;
    assign hdr_we = accept && !in_last && (count_reg < HDR_COUNT);
    assign expected_count = HDR_COUNT + {1'b0, hdr_reg[8]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            net_id_reg <= '0;
            proto_reg  <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_NET_ID:        net_id_reg <= cfg_data;
                REG_PROTO_VERSION: proto_reg  <= cfg_data[3:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_reg[count_reg[HDR_IDX_W-1:0]] <= in_byte;
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        crc_next     = crc_reg;
        ver_bad_next = ver_bad_reg;
        net_bad_next = net_bad_reg;
        push         = 1'b0;
        entry        = '0;
        if (accept)
        begin
            if (!in_last)
            begin
                if (count_reg == 9'd0)
                begin
                    ver_bad_next = (in_byte[7:4] != proto_reg);
                end
                if (count_reg == 9'd1)
                begin
                    net_bad_next = (in_byte != net_id_reg);
                end
                crc_next = crc8_byte(crc_reg, in_byte);
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 9'd1;
                end
                push = (count_reg >= HDR_COUNT);
                entry.result_kind  = KIND_PAYLOAD;
                entry.payload_byte = in_byte;
            end
            else
            begin
                push = 1'b1;
                entry.result_kind = KIND_STATUS;
                if (count_reg < HDR_COUNT)
                begin
                    entry.status = ST_SHORT;
                end
                else
                begin
                    if (ver_bad_reg)
                        entry.status = ST_VERSION;
                    else if (net_bad_reg)
                        entry.status = ST_NETWORK;
                    else if (count_reg != expected_count)
                        entry.status = ST_LENGTH;
                    else if (crc_reg != in_byte)
                        entry.status = ST_CRC;
                    else
                        entry.status = ST_OK;
                    entry.frame_flags = hdr_reg[0][3:0];
                    entry.msg_type    = hdr_reg[2];
                    entry.building    = hdr_reg[3];
                    entry.room        = {hdr_reg[4], hdr_reg[5]};
                    entry.unit_number = hdr_reg[6];
                    entry.transaction = hdr_reg[7];
                    entry.payload_len = hdr_reg[8];
                end
                count_next   = '0;
                crc_next     = '0;
                ver_bad_next = 1'b0;
                net_bad_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            crc_reg     <= '0;
            ver_bad_reg <= 1'b0;
            net_bad_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            ver_bad_reg <= ver_bad_next;
            net_bad_reg <= net_bad_next;
        end
    end

endmodule

// ----- rtl/rfd_queue.sv -----
module rfd_queue
    import rfd_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    q_valid,
    output result_t q_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    result_t        mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           do_push;
    logic           do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- rtl/rfd_back.sv -----
module rfd_back
    import rfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    input  result_t q_data,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign q_pop     = q_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        if (q_pop)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            data_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

endmodule

// ----- rtl/rfd_checker.sv -----
`include "radio_frame_deframer_crc8_top_macros.svh"

module rfd_checker
    import rfd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [0:0]  m_tuser
);

    logic       out_hold;
    logic       payload_out;
    logic       status_out;
    logic       short_out;
    logic       eof_in;
    logic [2:0] st_code;

    assign st_code     = m_tdata[10:8];
    assign out_hold    = m_tvalid && !m_tready;
    assign payload_out = m_tvalid && (m_tuser == KIND_PAYLOAD);
    assign status_out  = m_tvalid && (m_tuser == KIND_STATUS);
    assign short_out   = status_out && (st_code == ST_SHORT);
    assign eof_in      = s_tvalid && s_tready && s_tlast;

    `RFD_ASSERT_NEXT(a_out_stable, clk, rst_n, out_hold, m_tvalid && $stable({m_tuser, m_tdata}))
    `RFD_ASSERT_NOW(a_payload_clean, clk, rst_n, payload_out, m_tdata[71:8] == '0)
    `RFD_ASSERT_NOW(a_status_range, clk, rst_n, status_out, st_code <= ST_CRC && m_tdata[7:0] == '0)
    `RFD_ASSERT_NOW(a_short_clean, clk, rst_n, short_out, m_tdata[71:11] == '0)
    `RFD_ASSERT_NEXT(a_eof_result, clk, rst_n, eof_in && !m_tvalid, ##1 m_tvalid)

endmodule

bind radio_frame_deframer_crc8_top rfd_checker u_rfd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
